FILE: rtl/core/llsf_pkg.sv
// Shared types, widths and saturation helpers for the least-squares line fit.
package llsf_pkg;

    localparam int XW    = 16;  // point coordinate width
    localparam int CNTW  = 7;   // point count width
    localparam int SXW   = 23;  // sum of x or y
    localparam int SXXW  = 38;  // sum of x*x and x*y (signed)
    localparam int PW    = 46;  // partial products and differences
    localparam int DVW   = 62;  // divider dividend width
    localparam int DSW   = 45;  // divider divisor width
    localparam int QW    = 32;  // Q16.16 word
    localparam int FPW   = 48;  // slope * x
    localparam int IPW   = 57;  // intercept numerator

    typedef struct packed {
        logic signed [XW-1:0] x_sample;
        logic signed [XW-1:0] y_sample;
        logic                 last_point;
    } t_in_item;

    typedef struct packed {
        logic signed [QW-1:0] fitted_y;
        logic signed [QW-1:0] slope;
        logic signed [QW-1:0] intercept;
        logic                 degenerate;
        logic                 overflowed;
        logic                 last_result;
    } t_out_item;

    // Apply sign to an unsigned quotient and clamp to 32 bits.
    function automatic logic signed [QW-1:0] sat_mag(input logic neg,
                                                     input logic [DVW-1:0] q);
        logic signed [QW-1:0] r;
        if (!neg) begin
            if (q > DVW'(32'h7fff_ffff)) r = 32'sh7fff_ffff;
            else r = $signed(q[QW-1:0]);
        end else begin
            if (q > DVW'(33'h0_8000_0000)) r = 32'sh8000_0000;
            else r = -$signed(q[QW-1:0]);
        end
        return r;
    endfunction

    function automatic logic signed [QW-1:0] sat_fit(input logic signed [FPW:0] v);
        logic signed [QW-1:0] r;
        if (v > (FPW+1)'(32'sh7fff_ffff)) r = 32'sh7fff_ffff;
        else if (v < -(FPW+1)'(33'sh0_8000_0000)) r = 32'sh8000_0000;
        else r = v[QW-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/llsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module llsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/llsf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module llsf_div #(
    parameter int DVW = 62,
    parameter int DSW = 45
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DVW-1:0] i_dividend,
    input  logic [DSW-1:0] i_divisor,
    output logic           o_done,
    output logic [DVW-1:0] o_quotient
);
    localparam int CW = $clog2(DVW + 1);

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [DSW-1:0] r_rem, n_rem;
    logic [DSW-1:0] r_dsr, n_dsr;
    logic [DVW-1:0] r_dvd, n_dvd;
    logic [DVW-1:0] r_q, n_q;
    logic [DSW:0]   shifted;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_dsr   = r_dsr;
        n_dvd   = r_dvd;
        n_q     = r_q;
        shifted = {r_rem, r_dvd[DVW-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DVW);
            n_rem  = '0;
            n_dsr  = i_divisor;
            n_dvd  = i_dividend;
        end else if (r_busy) begin
            n_dvd = {r_dvd[DVW-2:0], 1'b0};
            if (shifted >= {1'b0, r_dsr}) begin
                n_rem = DSW'(shifted - {1'b0, r_dsr});
                n_q   = {r_q[DVW-2:0], 1'b1};
            end else begin
                n_rem = shifted[DSW-1:0];
                n_q   = {r_q[DVW-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_dvd <= n_dvd;
        r_q   <= n_q;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

FILE: rtl/core/linear_least_squares_fit_core.sv
// Least-squares line fit: point accumulation, fit sequencer and replay of stored x.
// Points are taken one per cycle while the input is not stalled; the x values sit in a
// RAM, the sums in registers. After the last point the fit runs two divisions in the
// shared divider (none for a degenerate set), then each fitted item passes the RAM read,
// multiply and output states in turn and is loaded when the output slot is free.
// Input is stalled from the last point until the final fitted item is loaded.
// Synchronous active-low reset clears control, count, sums and the overflow and valid flags; RAM is not cleared.
module linear_least_squares_fit_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  llsf_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output llsf_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);
    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNTW = llsf_pkg::CNTW;
    localparam int SXW  = llsf_pkg::SXW;
    localparam int SXXW = llsf_pkg::SXXW;
    localparam int PW   = llsf_pkg::PW;
    localparam int DVW  = llsf_pkg::DVW;
    localparam int DSW  = llsf_pkg::DSW;
    localparam int QW   = llsf_pkg::QW;
    localparam int FPW  = llsf_pkg::FPW;
    localparam int IPW  = llsf_pkg::IPW;
    localparam int XW   = llsf_pkg::XW;

    localparam logic [3:0] ST_ACC = 4'd0;
    localparam logic [3:0] ST_MUL = 4'd1;
    localparam logic [3:0] ST_DIF = 4'd2;
    localparam logic [3:0] ST_SDV = 4'd3;
    localparam logic [3:0] ST_SWT = 4'd4;
    localparam logic [3:0] ST_SPR = 4'd5;
    localparam logic [3:0] ST_IDV = 4'd6;
    localparam logic [3:0] ST_IWT = 4'd7;
    localparam logic [3:0] ST_RD  = 4'd8;
    localparam logic [3:0] ST_FMU = 4'd9;
    localparam logic [3:0] ST_OUT = 4'd10;

    logic [3:0]              r_st, n_st;
    logic [CNTW-1:0]         r_count, n_count;
    logic [CNTW-1:0]         r_k, n_k;
    logic signed [SXW-1:0]   r_sx, n_sx, r_sy, n_sy;
    logic signed [SXXW-1:0]  r_sxx, n_sxx, r_sxy, n_sxy;
    logic                    r_ovf, n_ovf;
    logic signed [PW-1:0]    r_p1, r_p2, r_p3, r_p4;
    logic signed [PW-1:0]    r_den, r_num;
    logic                    r_neg, n_neg;
    logic signed [QW-1:0]    r_slope, n_slope, r_icpt, n_icpt;
    logic                    r_degen, n_degen;
    logic signed [55:0]      r_prod;
    logic signed [FPW-1:0]   r_fprod;
    logic                    r_ovalid, n_ovalid;
    llsf_pkg::t_out_item     r_oitem, n_oitem;

    logic                    in_acc, store_ok;
    logic signed [2*XW-1:0]  xx, xy;
    logic                    div_start, div_done;
    logic [DVW-1:0]          div_dvd, div_q;
    logic [DSW-1:0]          div_dsr;
    logic [PW-1:0]           num_mag;
    logic signed [IPW-1:0]   inum;
    logic [IPW-1:0]          inum_mag;
    logic [XW-1:0]           ram_rdata;
    logic                    slot_free;
    logic signed [CNTW:0]    n_s;

    assign o_in_stall = (r_st != ST_ACC);
    assign in_acc     = i_in_valid && (r_st == ST_ACC);
    assign store_ok   = (r_count < CNTW'(MAX_POINTS));
    assign xx = $signed(i_in_item.x_sample) * $signed(i_in_item.x_sample);
    assign xy = $signed(i_in_item.x_sample) * $signed(i_in_item.y_sample);
    assign n_s = $signed({1'b0, r_count});
    assign slot_free = !r_ovalid || !i_out_stall;

    assign num_mag  = r_num[PW-1] ? PW'(-r_num) : PW'(r_num);
    assign inum     = (IPW'(r_sy) <<< 16) - IPW'(r_prod);
    assign inum_mag = inum[IPW-1] ? IPW'(-inum) : IPW'(inum);

    llsf_ram #(.WIDTH(XW), .DEPTH(MAX_POINTS)) u_xram (
        .i_clk   (i_clk),
        .i_we    (in_acc && store_ok),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in_item.x_sample),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    llsf_div #(.DVW(DVW), .DSW(DSW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_st      = r_st;
        n_count   = r_count;
        n_k       = r_k;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_sxx     = r_sxx;
        n_sxy     = r_sxy;
        n_ovf     = r_ovf;
        n_neg     = r_neg;
        n_slope   = r_slope;
        n_icpt    = r_icpt;
        n_degen   = r_degen;
        n_ovalid  = r_ovalid && i_out_stall;
        n_oitem   = r_oitem;
        div_start = 1'b0;
        div_dvd   = DVW'(num_mag) << 16;
        div_dsr   = DSW'(r_den);
        unique case (r_st)
            ST_ACC: begin
                if (in_acc) begin
                    if (store_ok) begin
                        n_count = r_count + CNTW'(1);
                        n_sx    = r_sx + SXW'($signed(i_in_item.x_sample));
                        n_sy    = r_sy + SXW'($signed(i_in_item.y_sample));
                        n_sxx   = r_sxx + SXXW'(xx);
                        n_sxy   = r_sxy + SXXW'(xy);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_item.last_point) begin
                        n_st = ST_MUL;
                    end
                end
            end
            ST_MUL: n_st = ST_DIF;
            ST_DIF: begin
                if (r_count == '0) begin
                    n_count = '0;
                    n_sx    = '0;
                    n_sy    = '0;
                    n_sxx   = '0;
                    n_sxy   = '0;
                    n_ovf   = 1'b0;
                    n_st    = ST_ACC;
                end else begin
                    n_st = ST_SDV;
                end
            end
            ST_SDV: begin
                n_k = '0;
                if (r_den == '0) begin
                    n_degen = 1'b1;
                    n_slope = '0;
                    n_icpt  = '0;
                    n_st    = ST_RD;
                end else begin
                    n_degen   = 1'b0;
                    n_neg     = r_num[PW-1];
                    div_start = 1'b1;
                    div_dvd   = (DVW'(num_mag) << 16) + DVW'(r_den >>> 1);
                    div_dsr   = DSW'(r_den);
                    n_st      = ST_SWT;
                end
            end
            ST_SWT: begin
                if (div_done) begin
                    n_slope = llsf_pkg::sat_mag(r_neg, div_q);
                    n_st    = ST_SPR;
                end
            end
            ST_SPR: n_st = ST_IDV;
            ST_IDV: begin
                n_neg     = inum[IPW-1];
                div_start = 1'b1;
                div_dvd   = DVW'(inum_mag) + DVW'(r_count >> 1);
                div_dsr   = DSW'(r_count);
                n_st      = ST_IWT;
            end
            ST_IWT: begin
                if (div_done) begin
                    n_icpt = llsf_pkg::sat_mag(r_neg, div_q);
                    n_st   = ST_RD;
                end
            end
            ST_RD:  n_st = ST_FMU;
            ST_FMU: n_st = ST_OUT;
            ST_OUT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_oitem.fitted_y    = r_degen ? '0 : llsf_pkg::sat_fit(
                        (FPW+1)'(r_fprod) + (FPW+1)'(r_icpt));
                    n_oitem.slope       = r_slope;
                    n_oitem.intercept   = r_icpt;
                    n_oitem.degenerate  = r_degen;
                    n_oitem.overflowed  = r_ovf;
                    n_oitem.last_result = (r_k == r_count - CNTW'(1));
                    if (r_k == r_count - CNTW'(1)) begin
                        // set done: clear for the next one
                        n_count = '0;
                        n_sx    = '0;
                        n_sy    = '0;
                        n_sxx   = '0;
                        n_sxy   = '0;
                        n_ovf   = 1'b0;
                        n_st    = ST_ACC;
                    end else begin
                        n_k  = r_k + CNTW'(1);
                        n_st = ST_RD;
                    end
                end
            end
            default: n_st = ST_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_ACC;
            r_count  <= '0;
            r_k      <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_sxx    <= '0;
            r_sxy    <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_count  <= n_count;
            r_k      <= n_k;
            r_sx     <= n_sx;
            r_sy     <= n_sy;
            r_sxx    <= n_sxx;
            r_sxy    <= n_sxy;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
        r_neg   <= n_neg;
        r_slope <= n_slope;
        r_icpt  <= n_icpt;
        r_degen <= n_degen;
        r_oitem <= n_oitem;
        r_p1    <= n_s * PW'(r_sxx);
        r_p2    <= PW'(r_sx) * PW'(r_sx);
        r_p3    <= n_s * PW'(r_sxy);
        r_p4    <= PW'(r_sx) * PW'(r_sy);
        r_den   <= r_p1 - r_p2;
        r_num   <= r_p3 - r_p4;
        r_prod  <= 56'(r_slope) * 56'(r_sx);
        r_fprod <= FPW'(r_slope) * FPW'($signed(ram_rdata));
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;
endmodule

FILE: tb/tb_linear_least_squares_fit_core.sv
// Testbench for the least-squares line fit core: directed table, random point sets.
`timescale 1ns / 1ps

module tb_linear_least_squares_fit_core;

    localparam int  CAP        = 64;
    localparam int  HOLD_LEN   = 600;
    localparam int  SETTLE     = 400;
    localparam int  CYCLE_CAP  = 1000000;
    localparam int  RAND_ITEMS = 450;

    typedef struct {
        logic signed [llsf_pkg::XW-1:0] x;
        logic signed [llsf_pkg::XW-1:0] y;
        logic                           last;
        bit                             typed;
        logic signed [llsf_pkg::QW-1:0] exp_slope;
        logic signed [llsf_pkg::QW-1:0] exp_icpt;
        logic                           exp_degen;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    llsf_pkg::t_in_item  i_in_item = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    llsf_pkg::t_out_item o_out_item;
    logic                i_out_stall = 1'b0;

    linear_least_squares_fit_core #(.MAX_POINTS(CAP)) dut (.*);

    always #1 i_clk = ~i_clk;

    t_row                points[$];
    llsf_pkg::t_out_item fits_due[$];
    int                  errors = 0;
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    bit                  hold_req = 1'b0;
    int                  cycles = 0;

    // fit state mirrored: stored x at the block's width, sums in 64-bit integers
    logic signed [llsf_pkg::XW-1:0] held_x[CAP];
    int                             held_n = 0;
    longint                         acc_x = 0, acc_y = 0, acc_xx = 0, acc_xy = 0;
    bit                             dropped = 1'b0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("linear_least_squares_fit_core test failed");
            $finish;
        end
    end

    function automatic longint div_nearest(longint num, longint den);
        longint unsigned mag, q;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Take in one point; on the last mark queue one fitted item per held point.
    task automatic fit_point(t_row r);
        longint              den, slope, icpt;
        bit                  degen;
        llsf_pkg::t_out_item o;
        if (held_n < CAP) begin
            held_x[held_n] = r.x;
            held_n++;
            acc_x  += r.x;
            acc_y  += r.y;
            acc_xx += longint'(r.x) * r.x;
            acc_xy += longint'(r.x) * r.y;
        end else begin
            dropped = 1'b1;
        end
        if (!r.last) return;
        slope = 0;
        icpt  = 0;
        degen = 1'b1;
        if (held_n > 0) begin
            den = held_n * acc_xx - acc_x * acc_x;
            if (den > 0) begin
                degen = 1'b0;
                slope = clamp32(div_nearest((held_n * acc_xy - acc_x * acc_y) * 65536, den));
                icpt  = clamp32(div_nearest(acc_y * 65536 - slope * acc_x, held_n));
            end
        end
        for (int k = 0; k < held_n; k++) begin
            o.fitted_y    = degen ? 0 : llsf_pkg::QW'(clamp32(slope * held_x[k] + icpt));
            o.slope       = llsf_pkg::QW'(slope);
            o.intercept   = llsf_pkg::QW'(icpt);
            o.degenerate  = degen;
            o.overflowed  = dropped;
            o.last_result = (k == held_n - 1);
            // rows with hand-worked figures take those instead
            if (r.typed) begin
                o.slope      = r.exp_slope;
                o.intercept  = r.exp_icpt;
                o.degenerate = r.exp_degen;
                if (r.exp_degen) o.fitted_y = '0;
            end
            fits_due.insert(fits_due.size(), o);
        end
        held_n = 0;
        acc_x = 0; acc_y = 0; acc_xx = 0; acc_xy = 0;
        dropped = 1'b0;
    endtask

    function automatic t_row pt(int x, int y, bit last);
        t_row r;
        r = '{default: '0};
        r.x = llsf_pkg::XW'(x);
        r.y = llsf_pkg::XW'(y);
        r.last = last;
        return r;
    endfunction

    function automatic t_row pt_typed(int x, int y, int s, int c, bit d);
        t_row r;
        r = pt(x, y, 1'b1);
        r.typed = 1'b1;
        r.exp_slope = s;
        r.exp_icpt = c;
        r.exp_degen = d;
        return r;
    endfunction

    // Append one row to the stimulus table.
    task automatic add_row(t_row r);
        points.insert(points.size(), r);
    endtask

    task automatic build_stimulus();
        int len, xbase, xspan;
        int left;
        // lone point, then two sets of equal x: all degenerate
        add_row(pt_typed(5, 7, 0, 0, 1'b1));
        add_row(pt(3, 1, 1'b0));
        add_row(pt_typed(3, 9, 0, 0, 1'b1));
        add_row(pt(-32768, 32767, 1'b0));
        add_row(pt_typed(-32768, -32768, 0, 0, 1'b1));
        // extremes of both fields
        add_row(pt(-32768, -32768, 1'b0));
        add_row(pt_typed(32767, 32767, 65536, 0, 1'b0));
        add_row(pt(-32768, 32767, 1'b0));
        add_row(pt_typed(32767, -32768, -65536, -65536, 1'b0));
        // slope saturates high, then low
        add_row(pt(0, -32768, 1'b0));
        add_row(pt_typed(1, 32767, 32'sh7fff_ffff, -1073774592, 1'b0));
        add_row(pt(0, 32767, 1'b0));
        add_row(pt_typed(1, -32768, 32'sh8000_0000, 1073709056, 1'b0));
        add_row(pt(-7, 100, 1'b0));
        add_row(pt(0, -3, 1'b0));
        add_row(pt(12, 40, 1'b1));

        left = RAND_ITEMS;
        for (int s = 0; left > 0; s++) begin
            if (s % 9 == 4) len = $urandom_range(CAP - 2, CAP + 6);
            else len = $urandom_range(1, 10);
            if (len > left) len = left;
            left -= len;
            case ($urandom_range(0, 7))
                0: begin xbase = $urandom_range(0, 65535) - 32768; xspan = 0; end
                1, 2: begin xbase = $urandom_range(0, 40) - 20; xspan = 8; end
                default: begin xbase = -32768; xspan = 65535; end
            endcase
            for (int k = 0; k < len; k++) begin
                add_row(pt(xspan == 0 ? xbase : xbase + $urandom_range(0, xspan),
                           $urandom_range(0, 65535) - 32768, k == len - 1));
            end
        end
    endtask

    // Sender: offer items, idling at random; acceptance is seen at the falling edge.
    initial begin
        bit taken;
        bit paused;
        int total;
        paused = 1'b0;
        build_stimulus();
        total = points.size();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < total; i++) begin
            if (i == total / 4) send_idle_pct = 55;
            if (i == total / 2) begin
                send_idle_pct = 0;
                stall_pct = 55;
                hold_req = 1'b1;
            end
            if (i == 3 * total / 4) begin
                send_idle_pct = 30;
                stall_pct = 30;
            end
            // one pause until every fitted item is home
            if (!paused && i >= total / 3 && points[i - 1].last) begin
                paused = 1'b1;
                i_in_valid <= 1'b0;
                while (fits_due.size() != 0) @(posedge i_clk);
                repeat (SETTLE) @(posedge i_clk);
            end
            while ($urandom_range(1, 100) <= send_idle_pct) begin
                i_in_valid <= 1'b0;
                i_in_item <= llsf_pkg::t_in_item'({$urandom, 1'b0});
                @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_item <= '{x_sample: points[i].x, y_sample: points[i].y,
                           last_point: points[i].last};
            do begin
                @(negedge i_clk);
                taken = !o_in_stall;
                @(posedge i_clk);
            end while (!taken);
            fit_point(points[i]);
        end
        i_in_valid <= 1'b0;
        while (fits_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) $display("linear_least_squares_fit_core test passed");
        else $display("linear_least_squares_fit_core test failed");
        $finish;
    end

    // Receiver stall: random, plus one long hold-off counted here.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= $urandom_range(1, 100) <= stall_pct;
            end
        end
    end

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        llsf_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (fits_due.size() == 0) begin
                $error("fitted item with none expected");
                errors++;
            end else begin
                want = fits_due.pop_front();
                check_field("fitted_y", want.fitted_y, o_out_item.fitted_y);
                check_field("slope", want.slope, o_out_item.slope);
                check_field("intercept", want.intercept, o_out_item.intercept);
                check_field("degenerate", want.degenerate, o_out_item.degenerate);
                check_field("overflowed", want.overflowed, o_out_item.overflowed);
                check_field("last_result", want.last_result, o_out_item.last_result);
            end
        end
    end

endmodule
